// ----- sv/pacc_pkg.sv -----
// Shared constants and types for the parameter access requester.
package pacc_pkg;

	// Action codes of an input item.
	localparam logic [2:0] ACT_READ  = 3'd0;
	localparam logic [2:0] ACT_WRITE = 3'd1;
	localparam logic [2:0] ACT_RESP  = 3'd2;
	localparam logic [2:0] ACT_TIME  = 3'd3;
	localparam logic [2:0] ACT_RESET = 3'd4;
	localparam logic [2:0] ACT_FETCH = 3'd5;

	// Response command codes.
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;

	// Configuration register indexes.
	localparam logic [1:0] REG_BUSY_MAX    = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_MAX = 2'd1;
	localparam logic [1:0] REG_RESP_TMO    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0]  BUSY_MAX_RST    = 8'd3;
	localparam logic [7:0]  TIMEOUT_MAX_RST = 8'd3;
	localparam logic [15:0] RESP_TMO_RST    = 16'd200;

	// Frame header length in bytes.
	localparam logic [7:0] HDR_LEN = 8'd7;

	// Status codes reported in comm_state.
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_WAIT    = 3'd1;
	localparam logic [2:0] ST_RETRY   = 3'd2;
	localparam logic [2:0] ST_DONE    = 3'd3;
	localparam logic [2:0] ST_ERROR   = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;

	// One result item.
	typedef struct packed {
		logic [2:0]  comm_state;
		logic        send_valid;
		logic        send_write;
		logic [15:0] send_index;
		logic [7:0]  send_subindex;
		logic [7:0]  send_length;
		logic [31:0] send_data;
		logic        lock_held;
		logic [31:0] object_value;
		logic [7:0]  payload_length;
	} res_t;

endpackage

// ----- sv/parameter_access_retry_fsm.sv -----
// Parameter access requester: retrying read/write request state machine with result buffer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall    | action, index, subindex, write_data, ...
//  out     | output    | out_valid / out_stall  | comm_state, send_*, lock_held, object_value,
//          |           |                        | payload_length
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// Each accepted item is evaluated in its own cycle by one level of compares and one 32-bit add.
// Its result is registered and raises out_valid; the block takes one item per cycle while
// in_stall is low. Results sit in a two-entry buffer (result register plus skid register);
// in_stall rises only when both entries are full, so an item is still taken while
// one result waits. The asynchronous reset (arst_n low) returns the machine to idle with all
// counters, keys and captured values cleared and the configuration registers at their defaults.
module parameter_access_retry_fsm (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [15:0] index,
	input  logic [7:0]  subindex,
	input  logic [31:0] write_data,
	input  logic [2:0]  write_len,
	input  logic        lock_granted,
	input  logic        send_accepted,
	input  logic [1:0]  resp_cmd,
	input  logic [15:0] resp_index,
	input  logic [7:0]  resp_subindex,
	input  logic [7:0]  resp_frame_len,
	input  logic [31:0] resp_data_or_time,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  comm_state,
	output logic        send_valid,
	output logic        send_write,
	output logic [15:0] send_index,
	output logic [7:0]  send_subindex,
	output logic [7:0]  send_length,
	output logic [31:0] send_data,
	output logic        lock_held,
	output logic [31:0] object_value,
	output logic [7:0]  payload_length
);

	typedef enum logic [2:0] {
		PH_IDLE    = pacc_pkg::ST_IDLE,
		PH_WAIT    = pacc_pkg::ST_WAIT,
		PH_RETRY   = pacc_pkg::ST_RETRY,
		PH_DONE    = pacc_pkg::ST_DONE,
		PH_ERROR   = pacc_pkg::ST_ERROR,
		PH_TIMEOUT = pacc_pkg::ST_TIMEOUT
	} phase_t;

	// Configuration registers.
	logic [7:0]  busy_max_q;
	logic [7:0]  timeout_max_q;
	logic [15:0] resp_tmo_q;

	// Architectural state.
	phase_t      phase_q,       phase_d;
	logic [7:0]  busy_cnt_q,    busy_cnt_d;
	logic [7:0]  tmo_cnt_q,     tmo_cnt_d;
	logic        lock_q,        lock_d;
	logic        armed_q,       armed_d;
	logic [31:0] sent_time_q,   sent_time_d;
	logic [31:0] cur_time_q,    cur_time_d;
	logic [23:0] read_key_q,    read_key_d;
	logic [23:0] write_key_q,   write_key_d;
	logic [31:0] cap_value_q,   cap_value_d;
	logic [7:0]  cap_len_q,     cap_len_d;

	// Result buffer.
	logic           out_valid_q;
	logic           skid_valid_q;
	pacc_pkg::res_t out_q;
	pacc_pkg::res_t skid_q;
	pacc_pkg::res_t res;

	logic        in_acc;
	logic        out_take;
	logic        out_free;
	logic [23:0] req_key;
	logic [23:0] rsp_key;
	logic [31:0] deadline;
	logic        sent;
	logic        is_write;
	logic        active;
	logic [7:0]  busy_inc;

	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || out_take;
	assign in_stall = skid_valid_q;

	assign req_key  = {index, subindex};
	assign rsp_key  = {resp_index, resp_subindex};
	assign deadline = sent_time_q + {16'd0, resp_tmo_q};
	assign active   = (phase_q == PH_WAIT) || (phase_q == PH_RETRY);
	// The busy counter saturates at its top value.
	assign busy_inc = (busy_cnt_q == 8'hFF) ? busy_cnt_q : busy_cnt_q + 8'd1;

	// Next-state evaluation for the item at the input ports.
	always_comb begin
		phase_d     = phase_q;
		busy_cnt_d  = busy_cnt_q;
		tmo_cnt_d   = tmo_cnt_q;
		lock_d      = lock_q;
		armed_d     = armed_q;
		sent_time_d = sent_time_q;
		cur_time_d  = cur_time_q;
		read_key_d  = read_key_q;
		write_key_d = write_key_q;
		cap_value_d = cap_value_q;
		cap_len_d   = cap_len_q;
		sent        = 1'b0;
		is_write    = (action == pacc_pkg::ACT_WRITE);

		case (action)
			pacc_pkg::ACT_READ, pacc_pkg::ACT_WRITE: begin
				// Requests are taken only in idle or retry; elsewhere they are ignored.
				if ((phase_q == PH_IDLE) || (phase_q == PH_RETRY)) begin
					if (is_write) begin
						write_key_d = req_key;
					end else begin
						read_key_d = req_key;
					end
					lock_d = lock_granted;
					if (lock_granted) begin
						if (send_accepted) begin
							phase_d     = PH_WAIT;
							busy_cnt_d  = 8'd0;
							sent_time_d = cur_time_q;
							armed_d     = 1'b1;
							sent        = 1'b1;
						end else begin
							// Refused send: drop the lock and count a busy retry.
							lock_d     = 1'b0;
							busy_cnt_d = busy_inc;
							phase_d    = (busy_inc > busy_max_q) ? PH_ERROR : PH_RETRY;
						end
					end
				end
			end
			pacc_pkg::ACT_RESP: begin
				if ((resp_cmd == pacc_pkg::CMD_READ) && active && (rsp_key == read_key_q)) begin
					cap_len_d   = resp_frame_len - pacc_pkg::HDR_LEN;
					cap_value_d = resp_data_or_time;
					armed_d     = 1'b0;
					phase_d     = PH_DONE;
					lock_d      = 1'b0;
				end else if ((resp_cmd == pacc_pkg::CMD_WRITE) && active &&
						(rsp_key == write_key_q)) begin
					phase_d = PH_DONE;
					lock_d  = 1'b0;
					armed_d = 1'b0;
				end else begin
					// Mismatched or foreign response; lock and timer are left as they are.
					phase_d = PH_ERROR;
				end
			end
			pacc_pkg::ACT_TIME: begin
				cur_time_d = resp_data_or_time;
				// The deadline wraps; it expires only when strictly below the new time.
				if (armed_q && (deadline < resp_data_or_time)) begin
					armed_d = 1'b0;
					if (tmo_cnt_q < timeout_max_q) begin
						phase_d   = PH_RETRY;
						tmo_cnt_d = tmo_cnt_q + 8'd1;
						lock_d    = 1'b0;
					end else begin
						phase_d   = PH_TIMEOUT;
						tmo_cnt_d = 8'd0;
					end
				end
			end
			pacc_pkg::ACT_RESET: begin
				// The timer keeps its armed flag across a reset action.
				phase_d    = PH_IDLE;
				tmo_cnt_d  = 8'd0;
				busy_cnt_d = 8'd0;
				lock_d     = 1'b0;
			end
			pacc_pkg::ACT_FETCH: begin
				if (phase_q == PH_DONE) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// Unused action codes only report status.
			end
		endcase
	end

	// Result item; frame fields are zero when nothing is sent.
	always_comb begin
		res.comm_state     = phase_d;
		res.send_valid     = sent;
		res.send_write     = sent && is_write;
		res.send_index     = sent ? index : 16'd0;
		res.send_subindex  = sent ? subindex : 8'd0;
		res.send_length    = 8'd0;
		res.send_data      = 32'd0;
		if (sent) begin
			res.send_length = is_write ? (pacc_pkg::HDR_LEN + {5'd0, write_len})
					: pacc_pkg::HDR_LEN;
			res.send_data   = is_write ? write_data : 32'd0;
		end
		res.lock_held      = lock_d;
		res.object_value   = cap_value_d;
		res.payload_length = cap_len_d;
	end

	// Configuration registers; an index beyond the list writes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_max_q    <= pacc_pkg::BUSY_MAX_RST;
			timeout_max_q <= pacc_pkg::TIMEOUT_MAX_RST;
			resp_tmo_q    <= pacc_pkg::RESP_TMO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pacc_pkg::REG_BUSY_MAX:    busy_max_q    <= cfg_data[7:0];
				pacc_pkg::REG_TIMEOUT_MAX: timeout_max_q <= cfg_data[7:0];
				pacc_pkg::REG_RESP_TMO:    resp_tmo_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// State machine and its companion registers, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			busy_cnt_q  <= 8'd0;
			tmo_cnt_q   <= 8'd0;
			lock_q      <= 1'b0;
			armed_q     <= 1'b0;
			sent_time_q <= 32'd0;
			cur_time_q  <= 32'd0;
			read_key_q  <= 24'd0;
			write_key_q <= 24'd0;
			cap_value_q <= 32'd0;
			cap_len_q   <= 8'd0;
		end else if (in_acc) begin
			phase_q     <= phase_d;
			busy_cnt_q  <= busy_cnt_d;
			tmo_cnt_q   <= tmo_cnt_d;
			lock_q      <= lock_d;
			armed_q     <= armed_d;
			sent_time_q <= sent_time_d;
			cur_time_q  <= cur_time_d;
			read_key_q  <= read_key_d;
			write_key_q <= write_key_d;
			cap_value_q <= cap_value_d;
			cap_len_q   <= cap_len_d;
		end
	end

	// Valid bits of the result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= in_acc;
			end else begin
				out_valid_q  <= in_acc;
				skid_valid_q <= 1'b0;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the result buffer; the skid entry always holds the newer item.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (in_acc) begin
					skid_q <= res;
				end
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign comm_state     = out_q.comm_state;
	assign send_valid     = out_q.send_valid;
	assign send_write     = out_q.send_write;
	assign send_index     = out_q.send_index;
	assign send_subindex  = out_q.send_subindex;
	assign send_length    = out_q.send_length;
	assign send_data      = out_q.send_data;
	assign lock_held      = out_q.lock_held;
	assign object_value   = out_q.object_value;
	assign payload_length = out_q.payload_length;

	// The skid entry is only ever filled behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while result register is empty");

	// An item taken while the result register is blocked lands in the skid entry.
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("accepted item was not buffered behind a stalled result");

	// Waiting for a response always has the response timer running.
	a_wait_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT) |-> armed_q)
		else $error("waiting for a response without an armed timer");

	// A frame is only ever emitted together with the move to waiting.
	a_send_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.send_valid) |-> (out_q.comm_state == pacc_pkg::ST_WAIT))
		else $error("request frame emitted without entering the waiting state");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the parameter access requester state machine.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Action and response command codes that the package leaves unnamed.
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	localparam logic [1:0] CMD_OTHER    = 2'd2;
	localparam logic [1:0] CMD_SPARE    = 2'd3;

	// One input item, field for field as the ports carry it.
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] index;
		logic [7:0]  subindex;
		logic [31:0] write_data;
		logic [2:0]  write_len;
		logic        lock_granted;
		logic        send_accepted;
		logic [1:0]  resp_cmd;
		logic [15:0] resp_index;
		logic [7:0]  resp_subindex;
		logic [7:0]  resp_frame_len;
		logic [31:0] resp_data_or_time;
	} access_item_t;

	bit          clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [15:0] index;
	logic [7:0]  subindex;
	logic [31:0] write_data;
	logic [2:0]  write_len;
	logic        lock_granted;
	logic        send_accepted;
	logic [1:0]  resp_cmd;
	logic [15:0] resp_index;
	logic [7:0]  resp_subindex;
	logic [7:0]  resp_frame_len;
	logic [31:0] resp_data_or_time;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  comm_state;
	logic        send_valid;
	logic        send_write;
	logic [15:0] send_index;
	logic [7:0]  send_subindex;
	logic [7:0]  send_length;
	logic [31:0] send_data;
	logic        lock_held;
	logic [31:0] object_value;
	logic [7:0]  payload_length;

	parameter_access_retry_fsm dut (.*);

	// The testbench's own copy of the requester: phase, retry counters, channel lock,
	// response timer, stored request keys (index in the upper bits, subindex below) and
	// the data captured from the last matching read response.
	logic [2:0]  ph;
	logic [7:0]  busy_cnt;
	logic [7:0]  tmo_cnt;
	logic        lock_q;
	logic        armed;
	logic [31:0] sent_at;
	logic [31:0] now_t;
	logic [23:0] rd_key;
	logic [23:0] wr_key;
	logic [31:0] cap_value;
	logic [7:0]  cap_len;

	// Register settings as the block should hold them.
	logic [7:0]  busy_max;
	logic [7:0]  tmo_max;
	logic [15:0] resp_tmo;

	pacc_pkg::res_t pending_results[$];
	int   items_sent;
	int   results_checked;
	int   err_count;
	bit   pace_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result of one accepted item and advances the state copy.
	function automatic pacc_pkg::res_t predict_access(input access_item_t it);
		pacc_pkg::res_t r;
		logic [23:0] key;
		logic [23:0] rkey;
		logic [31:0] deadline;
		logic        active;
		logic        is_wr;
		r = '0;
		key = {it.index, it.subindex};
		rkey = {it.resp_index, it.resp_subindex};
		is_wr = (it.action == pacc_pkg::ACT_WRITE);
		active = (ph == pacc_pkg::ST_WAIT || ph == pacc_pkg::ST_RETRY);
		case (it.action)
			pacc_pkg::ACT_READ, pacc_pkg::ACT_WRITE: begin
				// Requests are taken only in idle or retry. The key is kept even
				// when the lock is refused; a refused send counts a busy retry.
				if (ph == pacc_pkg::ST_IDLE || ph == pacc_pkg::ST_RETRY) begin
					if (is_wr)
						wr_key = key;
					else
						rd_key = key;
					lock_q = it.lock_granted;
					if (it.lock_granted && it.send_accepted) begin
						ph = pacc_pkg::ST_WAIT;
						busy_cnt = '0;
						sent_at = now_t;
						armed = 1'b1;
						r.send_valid = 1'b1;
						r.send_write = is_wr;
						r.send_index = it.index;
						r.send_subindex = it.subindex;
						r.send_length = is_wr ? pacc_pkg::HDR_LEN + {5'b0, it.write_len}
							: pacc_pkg::HDR_LEN;
						r.send_data = is_wr ? it.write_data : '0;
					end else if (it.lock_granted) begin
						lock_q = 1'b0;
						if (busy_cnt != 8'hFF)
							busy_cnt++;
						ph = (busy_cnt > busy_max) ? pacc_pkg::ST_ERROR : pacc_pkg::ST_RETRY;
					end
				end
			end
			pacc_pkg::ACT_RESP: begin
				// Anything but a matching read or write response is an error, and an
				// error leaves the lock and the timer as they were.
				if (it.resp_cmd == pacc_pkg::CMD_READ && active && rkey == rd_key) begin
					cap_len = it.resp_frame_len - pacc_pkg::HDR_LEN;
					cap_value = it.resp_data_or_time;
					armed = 1'b0;
					ph = pacc_pkg::ST_DONE;
					lock_q = 1'b0;
				end else if (it.resp_cmd == pacc_pkg::CMD_WRITE && active &&
						rkey == wr_key) begin
					ph = pacc_pkg::ST_DONE;
					lock_q = 1'b0;
					armed = 1'b0;
				end else begin
					ph = pacc_pkg::ST_ERROR;
				end
			end
			pacc_pkg::ACT_TIME: begin
				// The deadline wraps at 32 bits and fires only when strictly passed.
				now_t = it.resp_data_or_time;
				deadline = sent_at + {16'h0000, resp_tmo};
				if (armed && deadline < now_t) begin
					if (tmo_cnt < tmo_max) begin
						ph = pacc_pkg::ST_RETRY;
						tmo_cnt++;
						lock_q = 1'b0;
					end else begin
						ph = pacc_pkg::ST_TIMEOUT;
						tmo_cnt = '0;
					end
					armed = 1'b0;
				end
			end
			pacc_pkg::ACT_RESET: begin
				// The timer is left armed on purpose.
				ph = pacc_pkg::ST_IDLE;
				tmo_cnt = '0;
				busy_cnt = '0;
				lock_q = 1'b0;
			end
			pacc_pkg::ACT_FETCH: begin
				if (ph == pacc_pkg::ST_DONE)
					ph = pacc_pkg::ST_IDLE;
			end
			default: ;
		endcase
		r.comm_state = ph;
		r.lock_held = lock_q;
		r.object_value = cap_value;
		r.payload_length = cap_len;
		return r;
	endfunction

	// Every field random, unused codes included.
	function automatic access_item_t random_item();
		access_item_t it;
		it.action = 3'($urandom);
		it.index = 16'($urandom);
		it.subindex = 8'($urandom);
		it.write_data = $urandom;
		it.write_len = 3'($urandom);
		it.lock_granted = 1'($urandom);
		it.send_accepted = 1'($urandom);
		it.resp_cmd = 2'($urandom);
		it.resp_index = 16'($urandom);
		it.resp_subindex = 8'($urandom);
		it.resp_frame_len = 8'($urandom);
		it.resp_data_or_time = $urandom;
		return it;
	endfunction

	task automatic drive_payload(input access_item_t it);
		action <= it.action;
		index <= it.index;
		subindex <= it.subindex;
		write_data <= it.write_data;
		write_len <= it.write_len;
		lock_granted <= it.lock_granted;
		send_accepted <= it.send_accepted;
		resp_cmd <= it.resp_cmd;
		resp_index <= it.resp_index;
		resp_subindex <= it.resp_subindex;
		resp_frame_len <= it.resp_frame_len;
		resp_data_or_time <= it.resp_data_or_time;
	endtask

	// Offers one item after a random gap and returns at the edge that takes it. The
	// values of in_stall read right after the edge are the ones the block saw there.
	task automatic send_item(input access_item_t it);
		int gap;
		gap = pace_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		drive_payload(it);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_access(it));
		items_sent++;
	endtask

	task automatic do_request(input logic wr, input logic [15:0] idx, input logic [7:0] sub,
		input logic [31:0] data, input logic [2:0] len, input logic lock, input logic ok);
		access_item_t it;
		it = random_item();
		it.action = wr ? pacc_pkg::ACT_WRITE : pacc_pkg::ACT_READ;
		it.index = idx;
		it.subindex = sub;
		it.write_data = data;
		it.write_len = len;
		it.lock_granted = lock;
		it.send_accepted = ok;
		send_item(it);
	endtask

	task automatic do_response(input logic [1:0] cmd, input logic [15:0] idx,
		input logic [7:0] sub, input logic [7:0] len, input logic [31:0] word);
		access_item_t it;
		it = random_item();
		it.action = pacc_pkg::ACT_RESP;
		it.resp_cmd = cmd;
		it.resp_index = idx;
		it.resp_subindex = sub;
		it.resp_frame_len = len;
		it.resp_data_or_time = word;
		send_item(it);
	endtask

	task automatic do_time(input logic [31:0] stamp);
		access_item_t it;
		it = random_item();
		it.action = pacc_pkg::ACT_TIME;
		it.resp_data_or_time = stamp;
		send_item(it);
	endtask

	task automatic do_simple(input logic [2:0] act);
		access_item_t it;
		it = random_item();
		it.action = act;
		send_item(it);
	endtask

	// Waits until every expected result has come back, plus a short settling margin.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges. The 8-bit registers get random
	// upper data bits, which the block must drop.
	task automatic apply_settings(input logic [7:0] b, input logic [7:0] t,
		input logic [15:0] r);
		cfg_we <= 1'b1;
		cfg_index <= pacc_pkg::REG_BUSY_MAX;
		cfg_data <= {8'($urandom), b};
		@(posedge clk);
		cfg_index <= pacc_pkg::REG_TIMEOUT_MAX;
		cfg_data <= {8'($urandom), t};
		@(posedge clk);
		cfg_index <= pacc_pkg::REG_RESP_TMO;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		busy_max = b;
		tmo_max = t;
		resp_tmo = r;
	endtask

	// One random item, chosen from the current phase so that most traffic forms
	// complete transactions: requests from idle or retry, responses that mostly match the
	// stored keys while waiting or in retry, times around the deadline while waiting, fetches
	// after done and reset actions after error or timeout. The rest is fully random noise.
	task automatic random_step();
		int          roll;
		logic [1:0]  cmd;
		logic [23:0] key;
		roll = $urandom_range(0, 99);
		if ((ph == pacc_pkg::ST_IDLE || ph == pacc_pkg::ST_RETRY) && roll < 75) begin
			do_request(1'($urandom), 16'($urandom), 8'($urandom), $urandom,
				3'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0);
		end else if ((ph == pacc_pkg::ST_WAIT && roll < 45) ||
				(ph == pacc_pkg::ST_RETRY && roll < 85)) begin
			cmd = $urandom_range(0, 1) != 0 ? pacc_pkg::CMD_WRITE : pacc_pkg::CMD_READ;
			key = (cmd == pacc_pkg::CMD_WRITE) ? wr_key : rd_key;
			if ($urandom_range(0, 9) == 0)
				key = key ^ (24'd1 << $urandom_range(0, 23));
			do_response(cmd, key[23:8], key[7:0], 8'($urandom), $urandom);
		end else if (ph == pacc_pkg::ST_WAIT && roll < 65) begin
			do_time(sent_at + $urandom_range(0, resp_tmo));
		end else if (ph == pacc_pkg::ST_WAIT && roll < 85) begin
			do_time(sent_at + resp_tmo + 32'd1 + $urandom_range(0, 500));
		end else if (ph == pacc_pkg::ST_DONE && roll < 70) begin
			do_simple(pacc_pkg::ACT_FETCH);
		end else if ((ph == pacc_pkg::ST_ERROR || ph == pacc_pkg::ST_TIMEOUT) && roll < 60) begin
			do_simple(pacc_pkg::ACT_RESET);
		end else begin
			send_item(random_item());
		end
	endtask

	// Random traffic; pacing on both sides is switched on or off every 25 items so
	// that some stretches run at full rate.
	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0)
				pace_on = ($urandom_range(0, 3) != 0);
			random_step();
		end
		pace_on = 1'b1;
	endtask

	// Fetch in idle and the two unused action codes leave the reset state untouched.
	task automatic test_idle_codes();
		do_simple(pacc_pkg::ACT_FETCH);
		do_simple(ACT_SPARE_LO);
		do_simple(ACT_SPARE_HI);
	endtask

	// A read and a write at the address extremes, each completed and fetched. The read
	// response carries a frame length of zero, so the payload length wraps around.
	task automatic test_read_write();
		do_request(1'b0, 16'hFFFF, 8'hFF, 32'h0, 3'd0, 1'b1, 1'b1);
		do_response(pacc_pkg::CMD_READ, 16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
		do_simple(pacc_pkg::ACT_FETCH);
		do_request(1'b1, 16'h0000, 8'h00, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1);
		do_response(pacc_pkg::CMD_WRITE, 16'h0000, 8'h00, 8'hFF, 32'h0);
		do_simple(pacc_pkg::ACT_FETCH);
	endtask

	// A request without the lock only stores its key. Refused sends then count up to
	// the error state, a request there is ignored, and a reset action clears it.
	task automatic test_busy_refusal();
		do_request(1'b0, 16'h1234, 8'h56, $urandom, 3'd2, 1'b0, 1'b1);
		repeat (4)
			do_request(1'b0, 16'h1234, 8'h56, $urandom, 3'd2, 1'b1, 1'b0);
		do_request(1'b1, 16'h4321, 8'h65, $urandom, 3'd3, 1'b1, 1'b1);
		do_simple(pacc_pkg::ACT_RESET);
	endtask

	// A foreign response in idle is an error. A request sent just below the top of the
	// time range has a deadline that wraps past zero, so a slightly later time already
	// passes it. A response with the wrong subindex and one with a foreign command both
	// end in error while the lock stays held.
	task automatic test_responses_and_deadline();
		do_response(CMD_SPARE, 16'h0000, 8'h00, 8'h07, $urandom);
		do_simple(pacc_pkg::ACT_RESET);
		do_time(32'hFFFF_FFF0);
		do_request(1'b0, 16'h0001, 8'h01, $urandom, 3'd1, 1'b1, 1'b1);
		do_time(32'hFFFF_FFF8);
		do_request(1'b1, 16'h00AA, 8'h55, 32'hA5A5_5A5A, 3'd4, 1'b1, 1'b1);
		do_response(pacc_pkg::CMD_WRITE, 16'h00AA, 8'h54, 8'h0B, $urandom);
		do_response(CMD_OTHER, 16'h00AA, 8'h55, 8'h0B, $urandom);
		do_simple(pacc_pkg::ACT_RESET);
	endtask

	task automatic test_random_defaults();
		run_random(100);
	endtask

	// Smallest settings first (every refusal and every timeout is final, the deadline
	// is the send time itself), then the largest.
	task automatic test_settings_extremes();
		drain();
		apply_settings(8'd0, 8'd0, 16'd0);
		run_random(100);
		drain();
		apply_settings(8'd255, 8'd255, 16'hFFFF);
		run_random(100);
	endtask

	task automatic test_settings_random();
		repeat (2) begin
			drain();
			apply_settings(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
				16'($urandom_range(0, 3000)));
			run_random(100);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endtask

	// Each result taken from the block is compared with the oldest expectation.
	always @(posedge clk) begin
		pacc_pkg::res_t got;
		pacc_pkg::res_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {comm_state, send_valid, send_write, send_index, send_subindex,
				send_length, send_data, lock_held, object_value, payload_length};
			if (pending_results.size() == 0) begin
				$error("result arrived with no item outstanding");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("comm_state", 32'(want.comm_state), 32'(got.comm_state));
				check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
				check_field("send_write", 32'(want.send_write), 32'(got.send_write));
				check_field("send_index", 32'(want.send_index), 32'(got.send_index));
				check_field("send_subindex", 32'(want.send_subindex),
					32'(got.send_subindex));
				check_field("send_length", 32'(want.send_length), 32'(got.send_length));
				check_field("send_data", want.send_data, got.send_data);
				check_field("lock_held", 32'(want.lock_held), 32'(got.lock_held));
				check_field("object_value", want.object_value, got.object_value);
				check_field("payload_length", 32'(want.payload_length),
					32'(got.payload_length));
				results_checked++;
			end
		end
	end

	// While pacing is on, the result side may stall for a random stretch before each result it takes.
	initial begin
		int hold;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			hold = pace_on ? $urandom_range(0, 7) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= pacc_pkg::REG_BUSY_MAX;
		cfg_data <= '0;
		in_valid <= 1'b0;
		drive_payload('0);
		pace_on = 1'b1;
		items_sent = 0;
		results_checked = 0;
		err_count = 0;
		// State after reset, defaults in the registers.
		ph = pacc_pkg::ST_IDLE;
		busy_cnt = '0;
		tmo_cnt = '0;
		lock_q = 1'b0;
		armed = 1'b0;
		sent_at = '0;
		now_t = '0;
		rd_key = '0;
		wr_key = '0;
		cap_value = '0;
		cap_len = '0;
		busy_max = pacc_pkg::BUSY_MAX_RST;
		tmo_max = pacc_pkg::TIMEOUT_MAX_RST;
		resp_tmo = pacc_pkg::RESP_TMO_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_codes();
		test_read_write();
		test_busy_refusal();
		test_responses_and_deadline();
		test_random_defaults();
		test_settings_extremes();
		test_settings_random();
		drain();

		$display("Sent %0d items and checked %0d results under five register settings,",
			items_sent, results_checked);
		$display("from all-zero limits to the largest, with paced and full-rate stretches.");
		if (err_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pacc_pkg.sv
sv/parameter_access_retry_fsm.sv
sim/tb.sv
